// File: rtl/core/i2c_bit_bang_master_macros.svh
// assertion helpers shared by the checker
`ifndef I2C_BIT_BANG_MASTER_MACROS_SVH
`define I2C_BIT_BANG_MASTER_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define I2C_BBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define I2C_BBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/i2c_bbm_pkg.sv
package i2c_bbm_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  localparam logic KindTick = 1'b1;

  localparam logic [4:0] LenStart = 5'd4;
  localparam logic [4:0] LenStop  = 5'd3;
  localparam logic [4:0] LenWrite = 5'd28;
  localparam logic [4:0] LenRead  = 5'd19;

  localparam logic [4:0] WrBitPhases = 5'd24;
  localparam logic [4:0] WrAckHigh   = 5'd25;
  localparam logic [4:0] WrAckLow    = 5'd26;
  localparam logic [4:0] RdBitPhases = 5'd16;
  localparam logic [4:0] RdAckHigh   = 5'd17;

  typedef struct packed {
    logic       kind;
    op_e        op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       rejected;
  } result_t;

  function automatic logic [4:0] seq_len(op_e op);
    logic [4:0] len;
    unique case (op)
      OP_START: len = LenStart;
      OP_STOP:  len = LenStop;
      OP_WRITE: len = LenWrite;
      default:  len = LenRead;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/core/i2c_bbm_if.sv
interface i2c_bbm_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] op;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, kind, op, tx_byte, send_ack, sda_in, input ready);
  modport sink (input valid, kind, op, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2c_bbm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       rejected;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rx_byte, rejected, input ready);
  modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                rx_byte, rejected, output ready);
endinterface

// File: rtl/core/i2c_bbm_in_stage.sv
module i2c_bbm_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  i2c_bbm_in_if.sink          cmd_i,
  input  logic                advance_i,
  output logic                valid_o,
  output i2c_bbm_pkg::item_t  item_o
);

  logic                valid_q;
  i2c_bbm_pkg::item_t  item_q;

  assign cmd_i.ready = !valid_q || advance_i;
  assign valid_o     = valid_q;
  assign item_o      = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.valid && cmd_i.ready) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      item_q.kind     <= cmd_i.kind;
      item_q.op       <= i2c_bbm_pkg::op_e'(cmd_i.op);
      item_q.tx_byte  <= cmd_i.tx_byte;
      item_q.send_ack <= cmd_i.send_ack;
      item_q.sda_in   <= cmd_i.sda_in;
    end
  end

endmodule

// File: rtl/core/i2c_bbm_seq.sv
module i2c_bbm_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic                  step_i,
  input  i2c_bbm_pkg::item_t    item_i,
  output i2c_bbm_pkg::result_t  res_o
);

  logic [15:0]       phase_ticks_q;
  i2c_bbm_pkg::op_e  op_q, op_d;
  logic              busy_q, busy_d;
  logic [4:0]        phase_q, phase_d;
  logic [15:0]       tick_q, tick_d;
  logic [7:0]        shift_q, shift_d;
  logic              ack_q, ack_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              oe_q, oe_d;
  logic [7:0]        rx_q, rx_d;

  logic              done;
  logic              rej;
  logic              enter;
  logic [4:0]        ph_sel;
  logic [4:0]        ph_next;
  logic [15:0]       cnt_inc;
  logic [15:0]       limit;
  logic [8:0]        wr_prod;
  logic [2:0]        wr_bit;
  logic [4:0]        wr_base;
  logic [4:0]        wr_diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= 16'd1;
    end else if (cfg_we_i) begin
      phase_ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= i2c_bbm_pkg::OP_START;
      busy_q  <= 1'b0;
      phase_q <= '0;
      tick_q  <= '0;
      shift_q <= '0;
      ack_q   <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      oe_q    <= 1'b0;
      rx_q    <= '0;
    end else if (step_i) begin
      op_q    <= op_d;
      busy_q  <= busy_d;
      phase_q <= phase_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
      ack_q   <= ack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      oe_q    <= oe_d;
      rx_q    <= rx_d;
    end
  end

  assign cnt_inc = tick_q + 16'd1;
  assign limit   = (phase_ticks_q == 16'd0) ? 16'd1 : phase_ticks_q;
  assign ph_next = phase_q + 5'd1;

  // sequencing and shift register
  always_comb begin
    op_d    = op_q;
    busy_d  = busy_q;
    phase_d = phase_q;
    tick_d  = tick_q;
    shift_d = shift_q;
    ack_d   = ack_q;
    rx_d    = rx_q;
    done    = 1'b0;
    rej     = 1'b0;
    enter   = 1'b0;
    ph_sel  = phase_q;
    if (step_i) begin
      if (item_i.kind != i2c_bbm_pkg::KindTick) begin
        if (busy_q) begin
          rej = 1'b1;
        end else begin
          op_d    = item_i.op;
          busy_d  = 1'b1;
          phase_d = '0;
          tick_d  = '0;
          ack_d   = item_i.send_ack;
          shift_d = (item_i.op == i2c_bbm_pkg::OP_WRITE) ? item_i.tx_byte : 8'd0;
          enter   = 1'b1;
          ph_sel  = '0;
        end
      end else if (busy_q) begin
        tick_d = cnt_inc;
        if (cnt_inc >= limit) begin
          tick_d = '0;
          if (op_q == i2c_bbm_pkg::OP_READ && phase_q < i2c_bbm_pkg::RdBitPhases &&
              !phase_q[0]) begin
            shift_d = {shift_q[6:0], item_i.sda_in};
          end
          if (ph_next >= i2c_bbm_pkg::seq_len(op_q)) begin
            busy_d  = 1'b0;
            done    = 1'b1;
            phase_d = '0;
            if (op_q == i2c_bbm_pkg::OP_READ) begin
              rx_d = shift_d;
            end
          end else begin
            phase_d = ph_next;
            enter   = 1'b1;
            ph_sel  = ph_next;
          end
        end
      end
    end
  end

  // bit index and sub-phase of a write: ph / 3 by reciprocal, valid below 24
  assign wr_prod = {4'd0, ph_sel} * 9'd11;
  assign wr_bit  = wr_prod[7:5];
  assign wr_base = {2'd0, wr_bit} + {1'b0, wr_bit, 1'b0};
  assign wr_diff = ph_sel - wr_base;

  // line levels on phase entry
  always_comb begin
    scl_d = scl_q;
    sda_d = sda_q;
    oe_d  = oe_q;
    if (enter) begin
      unique case (op_d)
        i2c_bbm_pkg::OP_START: begin
          unique case (ph_sel)
            5'd0:    begin oe_d = 1'b1; sda_d = 1'b1; end
            5'd1:    scl_d = 1'b1;
            5'd2:    begin oe_d = 1'b1; sda_d = 1'b0; end
            default: scl_d = 1'b0;
          endcase
        end
        i2c_bbm_pkg::OP_STOP: begin
          unique case (ph_sel)
            5'd0:    begin oe_d = 1'b1; sda_d = 1'b0; end
            5'd1:    scl_d = 1'b1;
            default: begin oe_d = 1'b1; sda_d = 1'b1; end
          endcase
        end
        i2c_bbm_pkg::OP_WRITE: begin
          if (ph_sel < i2c_bbm_pkg::WrBitPhases) begin
            case (wr_diff[1:0])
              2'd0: begin
                oe_d  = 1'b1;
                sda_d = shift_d[3'd7 - wr_bit];
              end
              2'd1:    scl_d = 1'b1;
              default: scl_d = 1'b0;
            endcase
          end else if (ph_sel == i2c_bbm_pkg::WrBitPhases) begin
            oe_d  = 1'b0;
            sda_d = 1'b1;
          end else if (ph_sel == i2c_bbm_pkg::WrAckHigh) begin
            scl_d = 1'b1;
          end else if (ph_sel == i2c_bbm_pkg::WrAckLow) begin
            scl_d = 1'b0;
          end else begin
            oe_d  = 1'b1;
            sda_d = 1'b0;
          end
        end
        default: begin
          if (ph_sel < i2c_bbm_pkg::RdBitPhases) begin
            if (ph_sel == 5'd0) begin
              oe_d  = 1'b0;
              sda_d = 1'b1;
            end
            scl_d = !ph_sel[0];
          end else if (ph_sel == i2c_bbm_pkg::RdBitPhases) begin
            oe_d  = 1'b1;
            sda_d = !ack_d;
          end else if (ph_sel == i2c_bbm_pkg::RdAckHigh) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
        end
      endcase
    end
  end

  assign res_o.scl_level = scl_d;
  assign res_o.sda_level = sda_d;
  assign res_o.sda_drive = oe_d;
  assign res_o.busy_res  = busy_d;
  assign res_o.done_res  = done;
  assign res_o.rx_byte   = rx_d;
  assign res_o.rejected  = rej;

endmodule

// File: rtl/core/i2c_bit_bang_master.sv
// an accepted beat is held in the input register; its result beat is registered in the output register when it steps
// throughput: one beat per cycle while the result side does not stall, input and output registers keep the pipe full
// a stall on the result side holds both stages, ready drops only when both are full
// reset: asynchronous, active low; lines released (scl 1, sda 1, sda undriven),
// idle sequencer, phase_ticks 1, rx_byte 0
module i2c_bit_bang_master (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  i2c_bbm_in_if.sink    cmd_i,
  i2c_bbm_out_if.source res_o
);

  logic                  s1_valid;
  i2c_bbm_pkg::item_t    s1_item;
  logic                  advance;
  i2c_bbm_pkg::result_t  res_d;
  logic                  out_valid_q;
  i2c_bbm_pkg::result_t  res_q;

  assign advance = !out_valid_q || res_o.ready;

  i2c_bbm_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  i2c_bbm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (s1_valid && advance),
    .item_i      (s1_item),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.scl_level = res_q.scl_level;
  assign res_o.sda_level = res_q.sda_level;
  assign res_o.sda_drive = res_q.sda_drive;
  assign res_o.busy_res  = res_q.busy_res;
  assign res_o.done_res  = res_q.done_res;
  assign res_o.rx_byte   = res_q.rx_byte;
  assign res_o.rejected  = res_q.rejected;

endmodule

// File: rtl/core/i2c_bbm_checker.sv
`include "i2c_bit_bang_master_macros.svh"

module i2c_bbm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       busy_i,
  input logic       done_i,
  input logic       rej_i,
  input logic [7:0] rx_byte_i
);

  `I2C_BBM_ASSERT_NEXT(a_res_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(rx_byte_i) && $stable(busy_i), "result beat changed while stalled")
  `I2C_BBM_ASSERT_NOW(a_done_idle, out_valid_i && done_i, !busy_i && !rej_i, "done beat with busy or reject")
  `I2C_BBM_ASSERT_NOW(a_rej_busy, out_valid_i && rej_i, busy_i, "reject reported while idle")

endmodule

bind i2c_bit_bang_master i2c_bbm_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .busy_i      (res_o.busy_res),
  .done_i      (res_o.done_res),
  .rej_i       (res_o.rejected),
  .rx_byte_i   (res_o.rx_byte)
);
